>>> rtl/core/mtf_pkg.sv
// Shared types and constants for the move-to-front codec.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtf_pkg;

   localparam int unsigned SYMBOL_W    = 8;
   localparam int unsigned ALPHABET    = 256;
   localparam int unsigned GROUP_SIZE  = 16;
   localparam int unsigned GROUP_COUNT = ALPHABET / GROUP_SIZE;

   // configuration port
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 1'b0;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_LOCATE,
      ST_MOVE
   } mtf_state_type;

   // control shared by every cell in the row
   typedef struct packed {
      logic load_identity;
      logic compare_en;
      logic move_en;
      logic decode;
   } mtf_cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/mtf_channels.sv
// Valid/ready channel interfaces for the move-to-front codec.
// Depends on mtf_pkg for the field widths.
`default_nettype none

interface mtf_req_if import mtf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] data_byte;
   logic                block_start;

   modport source (output valid, data_byte, block_start, input ready);
   modport sink   (input valid, data_byte, block_start, output ready);
endinterface

interface mtf_rsp_if import mtf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] result_byte;

   modport source (output valid, result_byte, input ready);
   modport sink   (input valid, result_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mtf_cell.sv
// One list cell: holds one list symbol, compares it (its index if decoding)
// with the word and shifts from its neighbour on a move. Depends on mtf_pkg.
`default_nettype none

module mtf_cell import mtf_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SYMBOL_W-1:0] cell_index,
   input  wire mtf_cell_ctl_type    ctl,
   input  wire logic [SYMBOL_W-1:0] data_byte,
   input  wire logic [SYMBOL_W-1:0] move_pos,
   input  wire logic [SYMBOL_W-1:0] prev_symbol,
   output      logic [SYMBOL_W-1:0] symbol,
   output      logic                hit
);

   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                hit_ff, hit_in;

   always_comb begin
      symbol_in = symbol_ff;
      if (ctl.load_identity) begin
         symbol_in = cell_index;
      end else if (ctl.move_en && (cell_index <= move_pos)) begin
         symbol_in = prev_symbol;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (ctl.compare_en) begin
         hit_in = ctl.decode ? (cell_index == data_byte) : (symbol_ff == data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_ff <= cell_index;
      end else begin
         symbol_ff <= symbol_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   assign symbol = symbol_ff;
   assign hit    = hit_ff;

endmodule

`default_nettype wire

>>> rtl/core/mtf_reduce.sv
// Two-level registered OR tree that turns the single hit of the cell row
// into its position and symbol. Depends on mtf_pkg.
`default_nettype none

module mtf_reduce import mtf_pkg::*; (
   input  wire logic                clock,
   input  wire logic [ALPHABET-1:0] hit,
   input  wire logic [SYMBOL_W-1:0] symbols [ALPHABET],
   output      logic [SYMBOL_W-1:0] found_pos,
   output      logic [SYMBOL_W-1:0] found_sym
);

   logic [SYMBOL_W-1:0] grp_pos_ff [GROUP_COUNT];
   logic [SYMBOL_W-1:0] grp_sym_ff [GROUP_COUNT];
   logic [SYMBOL_W-1:0] grp_pos_in [GROUP_COUNT];
   logic [SYMBOL_W-1:0] grp_sym_in [GROUP_COUNT];
   logic [SYMBOL_W-1:0] pos_ff, pos_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;

   // exactly one cell hits, so OR-ing masked values selects it
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_pos_in[g] = '0;
         grp_sym_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (hit[g*GROUP_SIZE + k]) begin
               grp_pos_in[g] = grp_pos_in[g] | SYMBOL_W'(g*GROUP_SIZE + k);
               grp_sym_in[g] = grp_sym_in[g] | symbols[g*GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      pos_in = '0;
      sym_in = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         pos_in = pos_in | grp_pos_ff[g];
         sym_in = sym_in | grp_sym_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_pos_ff <= grp_pos_in;
      grp_sym_ff <= grp_sym_in;
      pos_ff     <= pos_in;
      sym_ff     <= sym_in;
   end

   assign found_pos = pos_ff;
   assign found_sym = sym_ff;

endmodule

`default_nettype wire

>>> rtl/core/move_to_front_codec_unit.sv
// Move-to-front codec over all 256 byte values: a row of 256 cells holds
// the order list, one symbol per cell, with a registered OR tree and a small
// sequencer around it. Each word passes through five steps until its result
// sits in the output register: the word is taken (and the identity order
// restored on a block start), every cell compares at once, the group level
// and then the final level of the registered tree locate the single hit,
// and every cell at or ahead of the hit takes its neighbour's symbol while
// cell 0 takes the found symbol. No new word is taken before that sequence
// ends; the move step holds while the output register still carries a word
// the sink has not taken, so back-pressure stretches the sequence. The
// next word is taken as soon as the move is done, even while the previous
// result still waits in the output register. Register 0 (mode) at byte
// address 0: bit 0 clear encodes symbols to positions, set decodes positions
// to symbols. Write it only while the block is idle.
`default_nettype none

module move_to_front_codec_unit import mtf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mtf_req_if.sink                    req,
   mtf_rsp_if.source                  rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   // ------------------------------------------------------------------
   // Configuration: one mode bit, register index taken from the word
   // address bit; unknown indexes are dropped.
   // ------------------------------------------------------------------
   logic                   mode_ff, mode_in;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_write;

   assign csr_index = paddr[CSR_ADDR_W-1 -: CSR_INDEX_W];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_index == REG_MODE)) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == REG_MODE) begin
         prdata[0] = mode_ff;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   mtf_state_type       state_ff, state_in;
   logic [SYMBOL_W-1:0] data_ff, data_in;
   logic                req_accept;
   logic                out_free;
   logic                out_load;
   mtf_cell_ctl_type    cell_ctl;

   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp.valid || rsp.ready;

   always_comb begin
      state_in               = state_ff;
      req.ready              = 1'b0;
      out_load               = 1'b0;
      cell_ctl.load_identity = 1'b0;
      cell_ctl.compare_en    = 1'b0;
      cell_ctl.move_en       = 1'b0;
      cell_ctl.decode        = (mode_ff == MODE_DECODE);
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               // restore identity before the compare sees the list
               cell_ctl.load_identity = req.block_start;
               state_in               = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cell_ctl.compare_en = 1'b1;
            state_in            = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            // hold the move until the output register can take the result
            if (out_free) begin
               out_load         = 1'b1;
               cell_ctl.move_en = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign data_in = req_accept ? req.data_byte : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // ------------------------------------------------------------------
   // Cell row and locate tree
   // ------------------------------------------------------------------
   logic [SYMBOL_W-1:0] cell_sym [ALPHABET];
   logic [ALPHABET-1:0] cell_hit;
   logic [SYMBOL_W-1:0] found_pos;
   logic [SYMBOL_W-1:0] found_sym;

   for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
      logic [SYMBOL_W-1:0] prev_symbol;
      if (g == 0) begin : g_front
         assign prev_symbol = found_sym;
      end else begin : g_body
         assign prev_symbol = cell_sym[g-1];
      end
      mtf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (SYMBOL_W'(g)),
         .ctl         (cell_ctl),
         .data_byte   (data_ff),
         .move_pos    (found_pos),
         .prev_symbol (prev_symbol),
         .symbol      (cell_sym[g]),
         .hit         (cell_hit[g])
      );
   end

   mtf_reduce u_reduce (
      .clock     (clock),
      .hit       (cell_hit),
      .symbols   (cell_sym),
      .found_pos (found_pos),
      .found_sym (found_sym)
   );

   // ------------------------------------------------------------------
   // Output register: parts the result side from the cell row
   // ------------------------------------------------------------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_byte_ff, rsp_byte_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cell_ctl.decode ? found_sym : found_pos;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_byte = rsp_byte_ff;

endmodule

`default_nettype wire

>>> rtl/core/mtf_checker.sv
// Port-level checks for the move-to-front codec, bound to the top level.
// Depends on mtf_pkg and move_to_front_codec_unit.
`default_nettype none

module mtf_checker import mtf_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SYMBOL_W-1:0] rsp_result_byte,
   input wire logic                pready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_byte))
      else $error("result word changed while stalled");

   // one word at a time: no acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in flight");

   // once an accepted word's sequence ends, some result word is waiting
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##5 rsp_valid)
      else $error("no result five cycles after acceptance");

   // the configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("configuration port stalled");

endmodule

bind move_to_front_codec_unit mtf_checker u_mtf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_result_byte (rsp.result_byte),
   .pready          (pready)
);

`default_nettype wire
